// ===== rtl/hkra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hkra_pkg;

    // Report framing
    localparam logic [3:0] FULL_REPORT_LEN = 4'd8;

    // Key code boundaries
    localparam logic [7:0] CODE_FIRST_LTR = 8'h04;
    localparam logic [7:0] CAPS_MAX_CODE  = 8'h1D;
    localparam logic [7:0] TABLE_MAX_CODE = 8'h39;
    localparam logic [7:0] CAPS_LOCK_CODE = 8'h39;

    // Modifier values that select the shifted column
    localparam logic [7:0] MOD_LSHIFT     = 8'h02;
    localparam logic [7:0] MOD_RSHIFT     = 8'h20;

    // Input tdata layout, highest bit first
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USED_W  = 61;
    localparam int unsigned OUT_DATA_W = 16;

    typedef struct packed {
        logic [7:0] key_slot_f;
        logic [7:0] key_slot_e;
        logic [7:0] key_slot_d;
        logic [7:0] key_slot_c;
        logic [7:0] key_slot_b;
        logic [7:0] key_slot_a;
        logic [7:0] modifier_byte;
        logic [3:0] report_length;
        logic       transfer_ok;
    } report_t;

    typedef struct packed {
        logic       caps_state;
        logic [6:0] ascii_char;
        logic       char_valid;
    } result_t;

    // Characters for codes 0x1E..0x38 (digits, enter, escape, backspace, tab, space and punctuation)
    function automatic logic [6:0] punct_char(input logic [7:0] code, input logic shifted);
        logic [6:0] lo;
        logic [6:0] hi;
        begin
            lo = 7'h00;
            hi = 7'h00;
            case (code)
                8'h1E: begin lo = 7'h31; hi = 7'h21; end // 1 !
                8'h1F: begin lo = 7'h32; hi = 7'h40; end // 2 @
                8'h20: begin lo = 7'h33; hi = 7'h23; end // 3 #
                8'h21: begin lo = 7'h34; hi = 7'h24; end // 4 $
                8'h22: begin lo = 7'h35; hi = 7'h25; end // 5 %
                8'h23: begin lo = 7'h36; hi = 7'h5E; end // 6 ^
                8'h24: begin lo = 7'h37; hi = 7'h26; end // 7 &
                8'h25: begin lo = 7'h38; hi = 7'h2A; end // 8 *
                8'h26: begin lo = 7'h39; hi = 7'h28; end // 9 (
                8'h27: begin lo = 7'h30; hi = 7'h29; end // 0 )
                8'h28: begin lo = 7'h0A; hi = 7'h0A; end // enter
                8'h29: begin lo = 7'h1B; hi = 7'h1B; end // escape
                8'h2A: begin lo = 7'h08; hi = 7'h08; end // backspace
                8'h2B: begin lo = 7'h09; hi = 7'h09; end // tab
                8'h2C: begin lo = 7'h20; hi = 7'h20; end // space
                8'h2D: begin lo = 7'h2D; hi = 7'h5F; end // - _
                8'h2E: begin lo = 7'h3D; hi = 7'h2B; end // = +
                8'h2F: begin lo = 7'h5B; hi = 7'h7B; end // [ {
                8'h30: begin lo = 7'h5D; hi = 7'h7D; end // ] }
                8'h31: begin lo = 7'h5C; hi = 7'h7C; end // \ |
                8'h32: begin lo = 7'h23; hi = 7'h7E; end // # ~
                8'h33: begin lo = 7'h3B; hi = 7'h3A; end // ; :
                8'h34: begin lo = 7'h27; hi = 7'h22; end // ' "
                8'h35: begin lo = 7'h60; hi = 7'h7E; end // ` ~
                8'h36: begin lo = 7'h2C; hi = 7'h3C; end // , <
                8'h37: begin lo = 7'h2E; hi = 7'h3E; end // . >
                8'h38: begin lo = 7'h2F; hi = 7'h3F; end // / ?
                default: begin lo = 7'h00; hi = 7'h00; end
            endcase
            return shifted ? hi : lo;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hid_keyboard_report_to_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_*       in   64     one keyboard report per item
// m_*       out  16     one result per report: char_valid, ascii_char, caps_state
//
// One report in, one result out; an item can be taken on every clock while m_tready is high.
// A report passes the input register, then the decode into the result register.
// The key tracking and caps flag update in the same cycle the report is decoded,
// so the next report always sees the state left by the previous one.
// A stalled m_tready holds the result; the input register still takes one more item if it is empty.
// rst_n clears both valid flags, the last key code and the caps flag.

module hid_keyboard_report_to_ascii (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [0] transfer_ok, [4:1] report_length, [12:5] modifier_byte,
    // [20:13] key_slot_a, [28:21] key_slot_b, [36:29] key_slot_c,
    // [44:37] key_slot_d, [52:45] key_slot_e, [60:53] key_slot_f, [63:61] ignored
    input  wire logic [hkra_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] char_valid, [7:1] ascii_char, [8] caps_state, [15:9] zero
    output logic [hkra_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import hkra_pkg::*;

    logic       in_valid_reg;
    report_t    in_data_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    out_data_next;
    logic [7:0] last_key_reg;
    logic [7:0] last_key_next;
    logic       caps_reg;
    logic       caps_next;
    logic       advance;

    logic       report_ok;
    logic [7:0] pick_code;
    logic       is_new;
    logic       shifted;
    logic [6:0] char_code;

    // Handshake: decode moves when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 9){1'b0}}, out_data_reg};

    // Highest-priority nonzero key slot
    always_comb
    begin
        if (in_data_reg.key_slot_f != 8'h00)
            pick_code = in_data_reg.key_slot_f;
        else if (in_data_reg.key_slot_e != 8'h00)
            pick_code = in_data_reg.key_slot_e;
        else if (in_data_reg.key_slot_d != 8'h00)
            pick_code = in_data_reg.key_slot_d;
        else if (in_data_reg.key_slot_c != 8'h00)
            pick_code = in_data_reg.key_slot_c;
        else if (in_data_reg.key_slot_b != 8'h00)
            pick_code = in_data_reg.key_slot_b;
        else
            pick_code = in_data_reg.key_slot_a;
    end

    assign report_ok = in_data_reg.transfer_ok &&
                       (in_data_reg.report_length == FULL_REPORT_LEN);
    assign is_new    = report_ok && (pick_code != last_key_reg);
    assign shifted   = (caps_reg && (pick_code <= CAPS_MAX_CODE)) ||
                       (in_data_reg.modifier_byte == MOD_LSHIFT) ||
                       (in_data_reg.modifier_byte == MOD_RSHIFT);

    // Character table: zero below the first letter, letters by offset, the rest from the package table
    always_comb
    begin
        if (pick_code < CODE_FIRST_LTR)
            char_code = 7'h00;
        else if (pick_code <= CAPS_MAX_CODE)
            char_code = (shifted ? 7'h41 : 7'h61) + 7'(pick_code - CODE_FIRST_LTR);
        else
            char_code = punct_char(pick_code, shifted);
    end

    // Result and state update
    always_comb
    begin
        last_key_next            = last_key_reg;
        caps_next                = caps_reg;
        out_data_next.char_valid = 1'b0;
        out_data_next.ascii_char = 7'h00;
        if (is_new)
        begin
            last_key_next = pick_code;
            if (pick_code == CAPS_LOCK_CODE)
                caps_next = !caps_reg;
            else if (pick_code != 8'h00 && pick_code < TABLE_MAX_CODE)
            begin
                out_data_next.char_valid = 1'b1;
                out_data_next.ascii_char = char_code;
            end
        end
        out_data_next.caps_state = caps_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_key_reg  <= 8'h00;
            caps_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                last_key_reg  <= last_key_next;
                caps_reg      <= caps_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata[IN_USED_W-1:0];
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/hkra_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkra_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // No character means a zero character
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[7:1] == 7'h00))
        else $error("ascii_char set without char_valid");

    // Character code 0x01 never leaves the block
    a_no_caps_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:1] != 7'h01))
        else $error("caps key emitted as character");

    // With the output side empty the input side must be open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind hid_keyboard_report_to_ascii hkra_check u_hkra_check (.*);

`default_nettype wire
